[hdl/mono_sprite_row_blitter_unit_macros.svh]
// ----------------------------------------------------------------------------
// Sprite row blitter assertion macros
// Shared concurrent assertion forms, clocked on clk with reset rst_n.
// ----------------------------------------------------------------------------
`ifndef MONO_SPRITE_ROW_BLITTER_UNIT_MACROS_SVH
`define MONO_SPRITE_ROW_BLITTER_UNIT_MACROS_SVH

// checked only outside reset
`define MSRB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define MSRB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/msrb_pkg.sv]
// ----------------------------------------------------------------------------
// Sprite row blitter package
// Screen geometry, field widths, register codes and queue entry types.
// ----------------------------------------------------------------------------
package msrb_pkg;

  localparam int SCREEN_WIDTH   = 128;
  localparam int SCREEN_HEIGHT  = 64;
  localparam int MAX_ROW_PIXELS = 8;

  localparam int COL_W   = 3;   // column index within a row
  localparam int PIX_X_W = 7;
  localparam int PIX_Y_W = 6;
  localparam int COORD_W = 11;  // signed screen coordinate before clipping

  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = 2;
  localparam int QCNT_W  = 3;

  // configuration register indexes
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_LEFT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_TOP    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_HEIGHT = 3'd3;

  localparam logic [7:0] CLIP_LEFT_RST   = 8'd0;
  localparam logic [6:0] CLIP_TOP_RST    = 7'd0;
  localparam logic [7:0] CLIP_WIDTH_RST  = 8'd128;
  localparam logic [6:0] CLIP_HEIGHT_RST = 7'd64;

  // one classified row: visible set pixels by column, column 0 in bit 0
  typedef struct packed {
    logic [MAX_ROW_PIXELS-1:0] mask;
    logic [PIX_X_W-1:0]        x_base;
    logic [PIX_Y_W-1:0]        y;
  } q_entry_t;

  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_port_t;

endpackage

[hdl/mono_sprite_row_blitter_unit.sv]
// ----------------------------------------------------------------------------
// Monochrome sprite row blitter
// Turns one row of a 1-bit sprite into clipped pixel-set writes.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+-------------------------------
//  cfg      | in        | cfg_valid/cfg_ready  | cfg_index, cfg_data
//  in       | in        | in_valid/in_ready    | row bits, width, row, origin
//  out      | out       | out_valid/out_ready  | pixel_x, pixel_y, last_pixel
//
//  A row is classified in the front end; the back end then writes its visible
//  set pixels (1..8), one per cycle while the output is not stalled, and that
//  single write per cycle sets the rate. Rows with nothing visible give no item.
//  Reset: synchronous, active low; clip window returns to the full screen.
//  A four-entry queue lets input keep flowing while the output stalls;
//  in_ready drops only when that queue is full. cfg_ready is always high.
// ----------------------------------------------------------------------------
module mono_sprite_row_blitter_unit
  import msrb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration writes (clip window)
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // sprite rows
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_row_bits,
  input  logic [3:0]            in_sprite_width,
  input  logic [7:0]            in_row_index,
  input  logic signed [9:0]     in_origin_x,
  input  logic signed [9:0]     in_origin_y,
  // pixel writes
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [PIX_X_W-1:0]    out_pixel_x,
  output logic [PIX_Y_W-1:0]    out_pixel_y,
  output logic                  out_last_pixel
);

  q_port_t q_push;
  q_port_t q_head;
  logic    q_full;
  logic    q_pop;

  // front: clip registers, per-column visibility, drop empty rows
  msrb_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_row_bits     (in_row_bits),
    .in_sprite_width (in_sprite_width),
    .in_row_index    (in_row_index),
    .in_origin_x     (in_origin_x),
    .in_origin_y     (in_origin_y),
    .q_full          (q_full),
    .q_push          (q_push)
  );

  // queue of classified rows
  msrb_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .full  (q_full),
    .head  (q_head),
    .pop   (q_pop)
  );

  // back: one pixel write per cycle into the output register while it is not stalled
  msrb_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_pixel_x    (out_pixel_x),
    .out_pixel_y    (out_pixel_y),
    .out_last_pixel (out_last_pixel)
  );

endmodule

[hdl/msrb_fifo.sv]
// ----------------------------------------------------------------------------
// Sprite row blitter queue
// Short queue of classified rows between front and back.
// ----------------------------------------------------------------------------
`include "mono_sprite_row_blitter_unit_macros.svh"

module msrb_fifo
  import msrb_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  q_port_t push,
  output logic    full,
  output q_port_t head,
  input  logic    pop
);

  q_entry_t          mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_pop;

  assign full       = (count_r == QCNT_W'(QDEPTH));
  assign head.valid = (count_r != '0);
  assign head.entry = mem_r[rd_ptr_r];
  assign do_pop     = pop && head.valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + QPTR_W'(push.valid);
    rd_ptr_nxt = rd_ptr_r + QPTR_W'(do_pop);
    count_nxt  = count_r + QCNT_W'(push.valid) - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem_r[wr_ptr_r] <= push.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  `MSRB_ASSERT(a_fifo_no_overflow, push.valid |-> !full, "push into full queue")
  `MSRB_ASSERT(a_fifo_count_bound, count_r <= QCNT_W'(QDEPTH), "queue count beyond depth")
  `MSRB_ASSERT(a_fifo_head_nonempty, head.valid |-> (head.entry.mask != '0),
               "queued row has no pixel")

endmodule

[hdl/msrb_front.sv]
// ----------------------------------------------------------------------------
// Sprite row blitter front end
// Holds the clip window, accepts rows and classifies visible set pixels.
// ----------------------------------------------------------------------------
module msrb_front
  import msrb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_row_bits,
  input  logic [3:0]            in_sprite_width,
  input  logic [7:0]            in_row_index,
  input  logic signed [9:0]     in_origin_x,
  input  logic signed [9:0]     in_origin_y,
  input  logic                  q_full,
  output q_port_t               q_push
);

  logic [7:0] clip_left_r, clip_left_nxt;
  logic [6:0] clip_top_r, clip_top_nxt;
  logic [7:0] clip_width_r, clip_width_nxt;
  logic [6:0] clip_height_r, clip_height_nxt;

  logic [3:0]                width_sat;
  logic signed [COORD_W-1:0] dy;
  logic signed [COORD_W-1:0] x_lo, x_hi, y_lo, y_hi;
  logic                      row_vis;
  logic signed [COORD_W-1:0] dx [MAX_ROW_PIXELS];
  logic [3:0]                shift [MAX_ROW_PIXELS];
  logic [MAX_ROW_PIXELS-1:0] mask;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full;

  always_comb begin
    clip_left_nxt   = clip_left_r;
    clip_top_nxt    = clip_top_r;
    clip_width_nxt  = clip_width_r;
    clip_height_nxt = clip_height_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_CLIP_LEFT:   clip_left_nxt   = cfg_data;
        CFG_CLIP_TOP:    clip_top_nxt    = cfg_data[6:0];
        CFG_CLIP_WIDTH:  clip_width_nxt  = cfg_data;
        CFG_CLIP_HEIGHT: clip_height_nxt = cfg_data[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clip_left_r   <= CLIP_LEFT_RST;
      clip_top_r    <= CLIP_TOP_RST;
      clip_width_r  <= CLIP_WIDTH_RST;
      clip_height_r <= CLIP_HEIGHT_RST;
    end else begin
      clip_left_r   <= clip_left_nxt;
      clip_top_r    <= clip_top_nxt;
      clip_width_r  <= clip_width_nxt;
      clip_height_r <= clip_height_nxt;
    end
  end

  // window bounds as signed coordinates, exclusive upper edge
  assign x_lo = $signed({3'b000, clip_left_r});
  assign x_hi = $signed({2'b00, {1'b0, clip_left_r} + {1'b0, clip_width_r}});
  assign y_lo = $signed({4'b0000, clip_top_r});
  assign y_hi = $signed({3'b000, {1'b0, clip_top_r} + {1'b0, clip_height_r}});

  assign width_sat = (in_sprite_width > 4'(MAX_ROW_PIXELS)) ?
                     4'(MAX_ROW_PIXELS) : in_sprite_width;

  assign dy = $signed({in_origin_y[9], in_origin_y}) + $signed({3'b000, in_row_index});
  assign row_vis = (dy >= y_lo) && (dy < y_hi) && (dy >= 0) &&
                   (dy < COORD_W'(SCREEN_HEIGHT));

  // one lane per column, independent of each other
  always_comb begin
    for (int c = 0; c < MAX_ROW_PIXELS; c++) begin
      dx[c]    = $signed({in_origin_x[9], in_origin_x}) + $signed(COORD_W'(c));
      shift[c] = width_sat - 4'd1 - 4'(c);
      mask[c]  = (4'(c) < width_sat) && in_row_bits[shift[c][COL_W-1:0]] &&
                 (dx[c] >= x_lo) && (dx[c] < x_hi) && (dx[c] >= 0) &&
                 (dx[c] < COORD_W'(SCREEN_WIDTH));
    end
  end

  // rows with nothing to draw are taken and dropped here
  assign q_push.valid        = in_valid && in_ready && row_vis && (mask != '0);
  assign q_push.entry.mask   = mask;
  assign q_push.entry.x_base = in_origin_x[PIX_X_W-1:0];
  assign q_push.entry.y      = dy[PIX_Y_W-1:0];

endmodule

[hdl/msrb_back.sv]
// ----------------------------------------------------------------------------
// Sprite row blitter back end
// Walks the pixel mask of one row, one pixel write per cycle unless the output stalls.
// ----------------------------------------------------------------------------
`include "mono_sprite_row_blitter_unit_macros.svh"

module msrb_back
  import msrb_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  q_port_t            q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [PIX_X_W-1:0] out_pixel_x,
  output logic [PIX_Y_W-1:0] out_pixel_y,
  output logic               out_last_pixel
);

  logic                      busy_r, busy_nxt;
  logic [MAX_ROW_PIXELS-1:0] mask_r, mask_nxt;
  logic [PIX_X_W-1:0]        xb_r, xb_nxt;
  logic [PIX_Y_W-1:0]        y_r, y_nxt;

  logic                      ov_r, ov_nxt;
  logic [PIX_X_W-1:0]        ox_r, ox_nxt;
  logic [PIX_Y_W-1:0]        oy_r, oy_nxt;
  logic                      olast_r, olast_nxt;

  logic                      slot_free, emit, last;
  logic [MAX_ROW_PIXELS-1:0] pick, rest;
  logic [COL_W-1:0]          col;

  assign slot_free = !ov_r || out_ready;
  assign emit      = busy_r && slot_free;
  assign pick      = mask_r & (~mask_r + 1'b1);  // leftmost remaining column
  assign rest      = mask_r & ~pick;
  assign last      = (rest == '0);
  assign q_pop     = q_head.valid && (!busy_r || (emit && last));

  always_comb begin
    col = '0;
    for (int c = 0; c < MAX_ROW_PIXELS; c++) begin
      if (pick[c]) begin
        col = COL_W'(c);
      end
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    mask_nxt = mask_r;
    xb_nxt   = xb_r;
    y_nxt    = y_r;
    priority if (q_pop) begin
      busy_nxt = 1'b1;
      mask_nxt = q_head.entry.mask;
      xb_nxt   = q_head.entry.x_base;
      y_nxt    = q_head.entry.y;
    end else if (emit) begin
      busy_nxt = !last;
      mask_nxt = rest;
    end
  end

  always_comb begin
    ov_nxt    = ov_r;
    ox_nxt    = ox_r;
    oy_nxt    = oy_r;
    olast_nxt = olast_r;
    priority if (emit) begin
      ov_nxt    = 1'b1;
      ox_nxt    = xb_r + PIX_X_W'(col);
      oy_nxt    = y_r;
      olast_nxt = last;
    end else if (out_ready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mask_r  <= mask_nxt;
    xb_r    <= xb_nxt;
    y_r     <= y_nxt;
    ox_r    <= ox_nxt;
    oy_r    <= oy_nxt;
    olast_r <= olast_nxt;
  end

  assign out_valid      = ov_r;
  assign out_pixel_x    = ox_r;
  assign out_pixel_y    = oy_r;
  assign out_last_pixel = olast_r;

  `MSRB_ASSERT(a_back_busy_mask, busy_r |-> (mask_r != '0), "busy with empty mask")
  `MSRB_ASSERT_ALWAYS(a_back_reset_idle, !rst_n |=> (!busy_r && !ov_r),
                      "back end not idle after reset")

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite row blitter testbench
// Drives sprite rows and clip window writes with random idling on both
// channels. A scoreboard predicts the clipped pixel writes of each row and
// checks every write from the block, in order, field by field.
// ----------------------------------------------------------------------------
module tb_top
  import msrb_pkg::*;
;

  localparam int LIMIT_CYCLES = 200000;
  // short quiet spell after the last write before the window changes
  localparam int DRAIN_CYCLES = 16;
  localparam int PHASE_ROWS   = 18;
  localparam int PHASES       = 6;
  localparam int MAX_REPORTS  = 10;
  // first index past the clip window registers; writes there are ignored
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_FIRST = CFG_CLIP_HEIGHT + 3'd1;

  // one expected pixel write
  typedef struct packed {
    logic [PIX_X_W-1:0] x;
    logic [PIX_Y_W-1:0] y;
    logic               last;
  } pixel_write_t;

  class pixel_scoreboard;
    pixel_write_t writes_due[$];
    logic [7:0] clip_left   = CLIP_LEFT_RST;
    logic [6:0] clip_top    = CLIP_TOP_RST;
    logic [7:0] clip_width  = CLIP_WIDTH_RST;
    logic [6:0] clip_height = CLIP_HEIGHT_RST;
    int rows_seen;
    int writes_checked;
    int mismatches;
    int cfg_writes;

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      cfg_writes++;
      case (idx)
        CFG_CLIP_LEFT:   clip_left   = data;
        CFG_CLIP_TOP:    clip_top    = data[6:0];
        CFG_CLIP_WIDTH:  clip_width  = data;
        CFG_CLIP_HEIGHT: clip_height = data[6:0];
        default: ;  // unused index, no effect
      endcase
    endfunction

    // inside both the clip span and the screen
    function bit on_window(int pos, int lo, int len, int screen);
      return pos >= lo && pos < lo + len && pos >= 0 && pos < screen;
    endfunction

    // accepted row: queue its visible set pixels left to right
    function void note_row(logic [7:0] bits, logic [3:0] w, logic [7:0] row,
                           logic signed [9:0] ox, logic signed [9:0] oy);
      pixel_write_t row_writes[$];
      pixel_write_t pw;
      int wid;
      int dx;
      int dy;
      rows_seen++;
      wid = (w > MAX_ROW_PIXELS) ? MAX_ROW_PIXELS : int'(w);
      dy = int'(oy) + int'(row);
      if (!on_window(dy, int'(clip_top), int'(clip_height), SCREEN_HEIGHT))
        return;
      for (int col = 0; col < wid; col++) begin
        dx = int'(ox) + col;
        if (!on_window(dx, int'(clip_left), int'(clip_width), SCREEN_WIDTH))
          continue;
        if (!bits[wid - 1 - col])
          continue;
        pw.x = dx[PIX_X_W-1:0];
        pw.y = dy[PIX_Y_W-1:0];
        pw.last = 1'b0;
        row_writes.push_back(pw);
      end
      if (row_writes.size() > 0)
        row_writes[row_writes.size() - 1].last = 1'b1;
      foreach (row_writes[i])
        writes_due.push_back(row_writes[i]);
    endfunction

    function void check_write(logic [PIX_X_W-1:0] x, logic [PIX_Y_W-1:0] y, logic last);
      pixel_write_t exp_w;
      if (writes_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected pixel write x=%0d y=%0d last=%0b", x, y, last);
        return;
      end
      exp_w = writes_due.pop_front();
      writes_checked++;
      if (exp_w.x !== x || exp_w.y !== y || exp_w.last !== last) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("pixel write mismatch: expected x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
                   exp_w.x, exp_w.y, exp_w.last, x, y, last);
      end
    endfunction
  endclass

  // block inputs, all known from time zero
  logic                  clk             = 1'b0;
  logic                  rst_n           = 1'b0;
  logic                  cfg_valid       = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index       = '0;
  logic [CFG_DATA_W-1:0] cfg_data        = '0;
  logic                  in_valid        = 1'b0;
  logic [7:0]            in_row_bits     = '0;
  logic [3:0]            in_sprite_width = '0;
  logic [7:0]            in_row_index    = '0;
  logic signed [9:0]     in_origin_x     = '0;
  logic signed [9:0]     in_origin_y     = '0;
  logic                  out_ready       = 1'b0;
  // block outputs
  logic                  cfg_ready;
  logic                  in_ready;
  logic                  out_valid;
  logic [PIX_X_W-1:0]    out_pixel_x;
  logic [PIX_Y_W-1:0]    out_pixel_y;
  logic                  out_last_pixel;

  pixel_scoreboard sb;
  bit calm = 1'b0;     // no idling on either side while set
  int cycles = 0;

  mono_sprite_row_blitter_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_row_bits    (in_row_bits),
    .in_sprite_width(in_sprite_width),
    .in_row_index   (in_row_index),
    .in_origin_x    (in_origin_x),
    .in_origin_y    (in_origin_y),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_pixel_x    (out_pixel_x),
    .out_pixel_y    (out_pixel_y),
    .out_last_pixel (out_last_pixel)
  );

  always #1 clk = ~clk;

  // receiver stalls at random with a chance of about 9 in 100, never while calm
  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(0, 99) >= 9);
  end

  // all handshakes are sampled at the edge, before any new drive lands
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready)
        sb.write_reg(cfg_index, cfg_data);
      if (in_valid && in_ready)
        sb.note_row(in_row_bits, in_sprite_width, in_row_index, in_origin_x, in_origin_y);
      if (out_valid && out_ready)
        sb.check_write(out_pixel_x, out_pixel_y, out_last_pixel);
    end
  end

  // run guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d writes still due", cycles, sb.writes_due.size());
      $display("tb_top: errors");
      $finish;
    end
  end

  // present one row and hold it until taken; valid stays high on return
  task automatic send_row(input logic [7:0] bits, input logic [3:0] w,
                          input logic [7:0] row, input logic signed [9:0] ox,
                          input logic signed [9:0] oy);
    in_valid        <= 1'b1;
    in_row_bits     <= bits;
    in_sprite_width <= w;
    in_row_index    <= row;
    in_origin_x     <= ox;
    in_origin_y     <= oy;
    do @(posedge clk); while (!in_ready);
  endtask

  // one register write; valid is left high for a following write
  task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_window(input logic [7:0] left, input logic [7:0] top,
                            input logic [7:0] width, input logic [7:0] height);
    cfg_put(CFG_CLIP_LEFT, left);
    cfg_put(CFG_CLIP_TOP, top);
    cfg_put(CFG_CLIP_WIDTH, width);
    cfg_put(CFG_CLIP_HEIGHT, height);
    cfg_valid <= 1'b0;
  endtask

  // wait for every due write, then a short quiet spell; the first edge lets
  // the scoreboard note a row taken at the edge we returned on
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.writes_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // random sender gap before about 9 items of 100
  task automatic maybe_idle();
    if (!calm && $urandom_range(0, 99) < 9) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  // mostly rows aimed at the clip window, some fully random noise
  task automatic rand_row();
    int mode;
    int dx;
    int dy;
    int row;
    logic [7:0] bits;
    logic [3:0] w;
    mode = $urandom_range(0, 9);
    bits = 8'($urandom);
    if (mode == 0) begin
      send_row(bits, 4'($urandom), 8'($urandom), 10'($urandom), 10'($urandom));
    end else begin
      w   = (mode == 1) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(1, 8));
      row = $urandom_range(0, 15);
      dx  = int'(sb.clip_left) - 8 + $urandom_range(0, int'(sb.clip_width) + 8);
      dy  = int'(sb.clip_top) - 2 + $urandom_range(0, int'(sb.clip_height) + 3);
      send_row(bits, w, 8'(row), 10'(dx), 10'(dy - row));
    end
  endtask

  initial begin
    sb = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // full screen after reset: corners, edges, width saturation, empties
    maybe_idle(); send_row(8'hFF, 4'd8, 8'd0, 10'sd0, 10'sd0);
    maybe_idle(); send_row(8'h81, 4'd8, 8'd63, 10'sd120, 10'sd0);
    maybe_idle(); send_row(8'hFF, 4'd15, 8'd5, 10'sd10, 10'sd10);
    maybe_idle(); send_row(8'hFF, 4'd9, 8'd1, 10'sd50, 10'sd20);
    maybe_idle(); send_row(8'hFF, 4'd0, 8'd0, 10'sd0, 10'sd0);     // zero width
    maybe_idle(); send_row(8'h00, 4'd8, 8'd2, 10'sd0, 10'sd0);     // no set bits
    maybe_idle(); send_row(8'hFF, 4'd8, 8'd3, -10'sd4, 10'sd0);    // off left edge
    maybe_idle(); send_row(8'hFF, 4'd8, 8'd4, 10'sd124, 10'sd0);   // off right edge
    maybe_idle(); send_row(8'hFF, 4'd8, 8'd255, -10'sd512, -10'sd512);
    maybe_idle(); send_row(8'hFF, 4'd8, 8'd255, 10'sd511, 10'sd511);
    maybe_idle(); send_row(8'hC3, 4'd8, 8'd255, 10'sd3, -10'sd200);
    maybe_idle(); send_row(8'hAA, 4'd4, 8'd6, 10'sd30, 10'sd0);    // upper bits unused
    maybe_idle(); send_row(8'h55, 4'd1, 8'd0, 10'sd127, 10'sd7);
    maybe_idle(); send_row(8'hFF, 4'd8, 8'd0, 10'sd40, 10'sd64);   // below screen
    maybe_idle(); send_row(8'h7F, 4'd7, 8'd0, 10'sd40, 10'sd63);

    // window reaching past the screen is cut at the screen edge
    settle();
    set_window(8'd100, 8'd40, 8'd255, 8'd127);
    maybe_idle(); send_row(8'hFF, 4'd8, 8'd23, 10'sd120, 10'sd40);
    maybe_idle(); send_row(8'hFF, 4'd8, 8'd0, 10'sd96, 10'sd40);
    maybe_idle(); send_row(8'hFF, 4'd8, 8'd0, 10'sd100, 10'sd39);  // above window

    // left edge past the screen
    settle();
    set_window(8'd128, 8'd0, 8'd128, 8'd64);
    maybe_idle(); send_row(8'hFF, 4'd8, 8'd0, 10'sd120, 10'sd0);

    // empty windows
    settle();
    set_window(8'd0, 8'd0, 8'd0, 8'd64);
    maybe_idle(); send_row(8'hFF, 4'd8, 8'd0, 10'sd0, 10'sd0);
    settle();
    set_window(8'd0, 8'd0, 8'd128, 8'd0);
    maybe_idle(); send_row(8'hFF, 4'd8, 8'd0, 10'sd0, 10'sd0);

    // small window, then writes to unused indexes must leave it alone
    settle();
    cfg_put(CFG_CLIP_LEFT, 8'd8);
    cfg_put(CFG_CLIP_TOP, 8'd4);
    cfg_put(CFG_CLIP_WIDTH, 8'd16);
    cfg_put(CFG_CLIP_HEIGHT, 8'd8);
    for (int k = 0; k < 4; k++)
      cfg_put(CFG_UNUSED_FIRST + 3'(k), 8'($urandom));
    cfg_valid <= 1'b0;
    maybe_idle(); send_row(8'hFF, 4'd8, 8'd4, 10'sd4, 10'sd0);
    maybe_idle(); send_row(8'hFF, 4'd8, 8'd12, 10'sd8, 10'sd0);   // one past bottom
    maybe_idle(); send_row(8'hFF, 4'd8, 8'd11, 10'sd20, 10'sd0);

    // random phases, one window each
    for (int p = 0; p < PHASES; p++) begin
      settle();
      calm = (p == 0);
      case (p)
        0: set_window(CLIP_LEFT_RST, 8'(CLIP_TOP_RST), CLIP_WIDTH_RST, 8'(CLIP_HEIGHT_RST));
        1: set_window(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        default: set_window(8'($urandom_range(0, 128)), 8'($urandom_range(0, 64)),
                            8'($urandom_range(0, 128)), 8'($urandom_range(0, 64)));
      endcase
      for (int i = 0; i < PHASE_ROWS; i++) begin
        maybe_idle();
        // hold off once until the block has emptied out
        if (p == 3 && i == PHASE_ROWS / 2) begin
          in_valid <= 1'b0;
          do @(posedge clk); while (sb.writes_due.size() != 0);
        end
        rand_row();
      end
    end

    settle();
    $display("summary: %0d rows, %0d pixel writes checked, %0d register writes, %0d mismatches",
             sb.rows_seen, sb.writes_checked, sb.cfg_writes, sb.mismatches);
    $display("summary: clip windows covered full screen, oversize, empty, offscreen and random");
    if (sb.mismatches == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

endmodule
